@@ design/puhg_pkg.sv @@
// shared types, constants and the message table of the paced udp header generator
package puhg_pkg;

  localparam int unsigned DESC_DEPTH = 2;

  localparam logic [3:0] HDR_LAST_IDX = 4'd6;
  localparam logic [3:0] MSG_LAST_IDX = 4'd11;

  localparam logic [31:0] DEST_IP      = 32'hC0A80003;
  localparam logic [47:0] BCAST_MAC    = 48'hFFFFFFFFFFFF;
  localparam logic [15:0] VER_IHL_TOS  = 16'h4500;
  localparam logic [15:0] FLAGS_FRAG   = 16'h4000;
  localparam logic [7:0]  TTL_VAL      = 8'd128;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [15:0] DGRAM_PORT   = 16'h1F90;
  localparam logic [15:0] IP_HDR_BYTES = 16'd20;
  // fixed halfwords of the header summed ahead of time
  localparam logic [18:0] CSUM_FIXED   = 19'h1C5BC;

  localparam logic [31:0] PACING_RESET  = 32'd125000000;
  localparam logic [31:0] BOARD_IP_RESET = 32'hC0A80002;
  localparam logic [15:0] UDP_LEN_RESET = 16'd28;
  localparam logic [15:0] IP_LEN_RESET  = 16'd48;

  localparam logic [2:0] REG_PACING   = 3'd0;
  localparam logic [2:0] REG_BOARD_IP = 3'd1;
  localparam logic [2:0] REG_UDP_LEN  = 3'd2;
  localparam logic [2:0] REG_IP_LEN   = 3'd3;
  localparam logic [2:0] REG_TX_BASE  = 3'd4;

  typedef struct packed {
    logic [15:0] ip_total;
    logic [15:0] ident;
    logic [15:0] udp_len;
    logic        echo;
    logic [47:0] dmac;
    logic        arp_req;
  } burst_desc_t;

  function automatic logic [31:0] msg_word(input logic [3:0] idx);
    logic [31:0] w;
    case (idx)
      4'd7:    w = 32'h48454C4C;
      4'd8:    w = 32'h4F202020;
      4'd9:    w = 32'h20202020;
      4'd10:   w = 32'h50455246;
      4'd11:   w = 32'h584C4142;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

endpackage

@@ design/puhg_front.sv @@
// tick front end: pacing counter, echo and arp bookkeeping, burst descriptor issue
module puhg_front
  import puhg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] pacing_count,
  input  logic [15:0] udp_len_default,
  input  logic [15:0] default_ip_total_length,
  input  logic        accept,
  input  logic        clear,
  input  logic        echo_arrived,
  input  logic [15:0] rx_udp_length,
  input  logic [15:0] rx_ip_total_length,
  input  logic        arp_hit,
  input  logic [47:0] arp_mac,
  output logic        push,
  output burst_desc_t push_desc
);

  logic [31:0] tick_count;
  logic [15:0] udp_length_now;
  logic [15:0] ip_total_now;
  logic [15:0] ip_ident;
  logic        echo_pending;
  logic        arp_waiting;

  logic [31:0] tick_next;
  logic [15:0] udp_cur;
  logic [15:0] ip_cur;
  logic        echo_cur;
  logic        fire;

  always_comb begin
    tick_next = tick_count + 32'd1;
    udp_cur   = echo_arrived ? rx_udp_length : udp_length_now;
    ip_cur    = echo_arrived ? rx_ip_total_length : ip_total_now;
    echo_cur  = echo_arrived | echo_pending;
    fire      = tick_next >= pacing_count;
    push      = accept & ~clear & fire;
    push_desc.ip_total = ip_cur;
    push_desc.ident    = ip_ident + 16'd1;
    push_desc.udp_len  = udp_cur;
    push_desc.echo     = echo_cur;
    push_desc.dmac     = arp_hit ? arp_mac : BCAST_MAC;
    push_desc.arp_req  = ~arp_hit & ~arp_waiting;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      udp_length_now <= UDP_LEN_RESET;
      ip_total_now   <= IP_LEN_RESET;
      ip_ident       <= '0;
      echo_pending   <= 1'b0;
      arp_waiting    <= 1'b0;
    end else if (accept) begin
      if (clear) begin
        tick_count     <= '0;
        udp_length_now <= udp_len_default;
        ip_total_now   <= default_ip_total_length;
        ip_ident       <= '0;
        echo_pending   <= 1'b0;
        arp_waiting    <= 1'b0;
      end else if (fire) begin
        tick_count   <= '0;
        ip_ident     <= ip_ident + 16'd1;
        echo_pending <= 1'b0;
        arp_waiting  <= ~arp_hit;
        if (echo_cur) begin
          udp_length_now <= udp_len_default;
          ip_total_now   <= default_ip_total_length;
        end else begin
          udp_length_now <= udp_cur;
          ip_total_now   <= ip_cur;
        end
      end else begin
        tick_count     <= tick_next;
        udp_length_now <= udp_cur;
        ip_total_now   <= ip_cur;
        echo_pending   <= echo_cur;
      end
    end
  end

endmodule

@@ design/puhg_queue.sv @@
// small flop queue of burst descriptors between front and back
module puhg_queue
  import puhg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  burst_desc_t push_desc,
  input  logic        pop,
  output burst_desc_t head,
  output logic        full,
  output logic        empty
);

  localparam int unsigned PW = $clog2(DESC_DEPTH);

  burst_desc_t         slots [DESC_DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [PW:0]         count;

  assign full  = count == (PW+1)'(DESC_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DESC_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DESC_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/puhg_back.sv @@
// burst back end: header checksum and word-by-word emission into the output register
module puhg_back
  import puhg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] board_ip,
  input  burst_desc_t head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  word_index,
  output logic [31:0] word_data,
  output logic        last,
  output logic [47:0] dst_mac,
  output logic [15:0] frame_length,
  output logic        arp_request
);

  burst_desc_t desc;
  logic        busy;
  logic [3:0]  idx;
  logic [18:0] sum;

  logic        adv;
  logic        is_last;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] csum;
  logic [31:0] data_w;
  logic [18:0] sum_next;

  always_comb begin
    adv      = ~out_valid | ~out_stall;
    pop      = adv & ~busy & ~empty;
    is_last  = desc.echo ? (idx == HDR_LAST_IDX) : (idx == MSG_LAST_IDX);
    sum_next = CSUM_FIXED + 19'(head.ip_total) + 19'(head.ident)
             + 19'(board_ip[31:16]) + 19'(board_ip[15:0]);
    fold1    = 17'(sum[15:0]) + 17'(sum[18:16]);
    fold2    = fold1[15:0] + 16'(fold1[16]);
    csum     = ~fold2;
    case (idx)
      4'd0:    data_w = {VER_IHL_TOS, desc.ip_total};
      4'd1:    data_w = {desc.ident, FLAGS_FRAG};
      4'd2:    data_w = {TTL_VAL, PROTO_UDP, csum};
      4'd3:    data_w = board_ip;
      4'd4:    data_w = DEST_IP;
      4'd5:    data_w = {DGRAM_PORT, DGRAM_PORT};
      4'd6:    data_w = {desc.udp_len, 16'h0};
      default: data_w = msg_word(idx);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (adv) begin
      if (busy) begin
        out_valid    <= 1'b1;
        word_index   <= idx;
        word_data    <= data_w;
        last         <= is_last;
        dst_mac      <= is_last ? desc.dmac : '0;
        frame_length <= is_last ? desc.udp_len + IP_HDR_BYTES : '0;
        arp_request  <= is_last & desc.arp_req;
        idx          <= idx + 4'd1;
        if (is_last) begin
          busy <= 1'b0;
        end
      end else begin
        out_valid <= 1'b0;
        if (!empty) begin
          desc <= head;
          sum  <= sum_next;
          busy <= 1'b1;
          idx  <= '0;
        end
      end
    end
  end

endmodule

@@ design/paced_udp_ipv4_header_generator_top.sv @@
// top level: register port, tick front end, descriptor queue and burst back end
// one tick is accepted per cycle while the two-entry burst queue has room
// a firing tick's descriptor is written to a queue slot, then loaded by the back end,
// whose first header word is then registered onto the outputs
// 7 words (echo) or 12 per burst, one per unstalled cycle, out_valid low between bursts
// ticks are held off only while two bursts wait in the queue
// rst (synchronous) restores register defaults, clears counters, flags and queued bursts
module paced_udp_ipv4_header_generator_top
  import puhg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        clear,
  input  logic        echo_arrived,
  input  logic [15:0] rx_udp_length,
  input  logic [15:0] rx_ip_total_length,
  input  logic        arp_hit,
  input  logic [47:0] arp_mac,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  word_index,
  output logic [31:0] word_data,
  output logic        last,
  output logic [47:0] dst_mac,
  output logic [15:0] frame_length,
  output logic        arp_request
);

  logic [31:0] pacing_count;
  logic [31:0] board_ip;
  logic [15:0] udp_len_default;
  logic [15:0] default_ip_total_length;
  logic [15:0] tx_base_address;

  logic        wr_en;
  logic        accept;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  burst_desc_t push_desc;
  burst_desc_t head;

  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite & pready;
  assign in_stall = full;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pacing_count            <= PACING_RESET;
      board_ip                <= BOARD_IP_RESET;
      udp_len_default         <= UDP_LEN_RESET;
      default_ip_total_length <= IP_LEN_RESET;
      tx_base_address         <= '0;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (paddr[4:2])
        REG_PACING:   pacing_count            <= pwdata;
        REG_BOARD_IP: board_ip                <= pwdata;
        REG_UDP_LEN:  udp_len_default         <= pwdata[15:0];
        REG_IP_LEN:   default_ip_total_length <= pwdata[15:0];
        REG_TX_BASE:  tx_base_address         <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_PACING:   prdata = pacing_count;
      REG_BOARD_IP: prdata = board_ip;
      REG_UDP_LEN:  prdata = {16'h0, udp_len_default};
      REG_IP_LEN:   prdata = {16'h0, default_ip_total_length};
      REG_TX_BASE:  prdata = {16'h0, tx_base_address};
      default:      prdata = '0;
    endcase
  end

  puhg_front u_front (
    .clk                     (clk),
    .rst                     (rst),
    .pacing_count            (pacing_count),
    .udp_len_default         (udp_len_default),
    .default_ip_total_length (default_ip_total_length),
    .accept                  (accept),
    .clear                   (clear),
    .echo_arrived            (echo_arrived),
    .rx_udp_length           (rx_udp_length),
    .rx_ip_total_length      (rx_ip_total_length),
    .arp_hit                 (arp_hit),
    .arp_mac                 (arp_mac),
    .push                    (push),
    .push_desc               (push_desc)
  );

  puhg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  puhg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .board_ip     (board_ip),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .word_index   (word_index),
    .word_data    (word_data),
    .last         (last),
    .dst_mac      (dst_mac),
    .frame_length (frame_length),
    .arp_request  (arp_request)
  );

endmodule

@@ sim/tb.sv @@
// testbench for the paced udp header generator: tick stream in, header and message words checked
module tb
  import puhg_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned RAND_PER_PHASE = 38;
  localparam int unsigned HDR_COUNT      = 7;
  localparam int unsigned FULL_COUNT     = 12;
  localparam logic [159:0] GREETING =
    160'h48454C4C_4F202020_20202020_50455246_584C4142;

  typedef struct packed {
    logic        clr;
    logic        echo;
    logic [15:0] rx_udp;
    logic [15:0] rx_ip;
    logic        hit;
    logic [47:0] mac;
  } tick_t;

  typedef struct packed {
    logic [3:0]  idx;
    logic [31:0] data;
    logic        last;
    logic [47:0] dmac;
    logic [15:0] flen;
    logic        req;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        clear = 1'b0;
  logic        echo_arrived = 1'b0;
  logic [15:0] rx_udp_length = '0;
  logic [15:0] rx_ip_total_length = '0;
  logic        arp_hit = 1'b0;
  logic [47:0] arp_mac = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  word_index;
  logic [31:0] word_data;
  logic        last;
  logic [47:0] dst_mac;
  logic [15:0] frame_length;
  logic        arp_request;

  tick_t tick_q[$];
  word_t datagram_q[$];
  tick_t offered;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;

  // register copies and datagram state
  logic [31:0] pacing_cfg, board_ip_cfg;
  logic [15:0] udp_dflt_cfg, ip_dflt_cfg, tx_base_cfg;
  logic [31:0] tick_cnt;
  logic [15:0] udp_len_now, ip_len_now, ident;
  logic        echo_pend, arp_wait;

  paced_udp_ipv4_header_generator_top DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .clear(clear), .echo_arrived(echo_arrived),
    .rx_udp_length(rx_udp_length), .rx_ip_total_length(rx_ip_total_length),
    .arp_hit(arp_hit), .arp_mac(arp_mac),
    .out_valid(out_valid), .out_stall(out_stall),
    .word_index(word_index), .word_data(word_data), .last(last),
    .dst_mac(dst_mac), .frame_length(frame_length), .arp_request(arp_request)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [3:0] idx,
                             input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s got %0h want %0h", idx, name, got, want));
  endtask

  task automatic restart_pacer();
    tick_cnt    = '0;
    udp_len_now = udp_dflt_cfg;
    ip_len_now  = ip_dflt_cfg;
    ident       = '0;
    echo_pend   = 1'b0;
    arp_wait    = 1'b0;
  endtask

  // one tick: may fire and queue the words of one datagram
  task automatic advance_pacer(input tick_t t);
    logic [31:0] hdr [HDR_COUNT];
    logic [31:0] sum;
    logic [47:0] dmac;
    logic        use_echo, req;
    int          n, i;
    word_t       w;
    if (t.clr) begin
      restart_pacer();
      return;
    end
    if (t.echo) begin
      udp_len_now = t.rx_udp;
      ip_len_now  = t.rx_ip;
      echo_pend   = 1'b1;
    end
    tick_cnt = tick_cnt + 32'd1;
    if (tick_cnt < pacing_cfg) return;
    tick_cnt  = '0;
    ident     = ident + 16'd1;
    use_echo  = echo_pend;
    echo_pend = 1'b0;
    req       = 1'b0;
    if (t.hit) begin
      dmac     = t.mac;
      arp_wait = 1'b0;
    end else begin
      if (!arp_wait) begin
        req      = 1'b1;
        arp_wait = 1'b1;
      end
      dmac = BCAST_MAC;
    end
    hdr[0] = {VER_IHL_TOS, ip_len_now};
    hdr[1] = {ident, FLAGS_FRAG};
    hdr[2] = {TTL_VAL, PROTO_UDP, 16'h0000};
    hdr[3] = board_ip_cfg;
    hdr[4] = DEST_IP;
    hdr[5] = {DGRAM_PORT, DGRAM_PORT};
    hdr[6] = {udp_len_now, 16'h0000};
    sum = '0;
    for (i = 0; i < 5; i++) sum = sum + hdr[i][31:16] + hdr[i][15:0];
    while (sum[31:16] != 0) sum = sum[15:0] + sum[31:16];
    hdr[2][15:0] = ~sum[15:0];
    n = use_echo ? HDR_COUNT : FULL_COUNT;
    for (i = 0; i < n; i++) begin
      w = '0;
      w.idx = 4'(i);
      if (i < HDR_COUNT) w.data = hdr[i];
      else w.data = GREETING[159 - 32 * (i - HDR_COUNT) -: 32];
      if (i == n - 1) begin
        w.last = 1'b1;
        w.dmac = dmac;
        w.flen = IP_HDR_BYTES + udp_len_now;
        w.req  = req;
      end
      datagram_q.push_back(w);
    end
    if (use_echo) begin
      udp_len_now = udp_dflt_cfg;
      ip_len_now  = ip_dflt_cfg;
    end
  endtask

  task automatic apb_write(input logic [2:0] reg_id, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_id, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_id)
      REG_PACING:   pacing_cfg   = value;
      REG_BOARD_IP: board_ip_cfg = value;
      REG_UDP_LEN:  udp_dflt_cfg = value[15:0];
      REG_IP_LEN:   ip_dflt_cfg  = value[15:0];
      REG_TX_BASE:  tx_base_cfg  = value[15:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] pace, input logic [31:0] bip,
                              input logic [15:0] udp, input logic [15:0] ipl,
                              input logic [15:0] base);
    apb_write(REG_PACING, pace);
    apb_write(REG_BOARD_IP, bip);
    apb_write(REG_UDP_LEN, {16'h0, udp});
    apb_write(REG_IP_LEN, {16'h0, ipl});
    apb_write(REG_TX_BASE, {16'h0, base});
  endtask

  // wait until every tick is taken and every word has come out
  task automatic settle();
    while (tick_q.size() != 0 || in_valid || datagram_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned s, input int unsigned r);
    send_idle_pct <= s;
    recv_idle_pct <= r;
  endtask

  function automatic tick_t mk_tick(input logic clr, input logic echo,
                                    input logic [15:0] udp, input logic [15:0] ipl,
                                    input logic hit, input logic [47:0] mac);
    tick_t t;
    t.clr    = clr;
    t.echo   = echo;
    t.rx_udp = udp;
    t.rx_ip  = ipl;
    t.hit    = hit;
    t.mac    = mac;
    return t;
  endfunction

  function automatic logic [15:0] some_length();
    logic [15:0] v;
    case ($urandom_range(7))
      0:       v = 16'h0000;
      1:       v = 16'hFFFF;
      2:       v = 16'($urandom_range(100));
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic tick_t random_tick();
    tick_t       t;
    logic [63:0] r;
    r        = {$urandom, $urandom};
    t.clr    = ($urandom_range(99) < 3);
    t.echo   = ($urandom_range(99) < 25);
    t.rx_udp = some_length();
    t.rx_ip  = some_length();
    t.hit    = ($urandom_range(99) < 70);
    t.mac    = ($urandom_range(15) == 0) ? BCAST_MAC : r[47:0];
    return t;
  endfunction

  // tick driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) advance_pacer(offered);
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = tick_q.pop_front();
        clear              <= offered.clr;
        echo_arrived       <= offered.echo;
        rx_udp_length      <= offered.rx_udp;
        rx_ip_total_length <= offered.rx_ip;
        arp_hit            <= offered.hit;
        arp_mac            <= offered.mac;
        in_valid           <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // word monitor
  always @(posedge clk) begin
    word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (datagram_q.size() == 0) begin
        report_mismatch($sformatf("word %0d data %h with no transaction pending",
                                  word_index, word_data));
      end else begin
        want = datagram_q.pop_front();
        check_field("word_index", want.idx, 64'(word_index), 64'(want.idx));
        check_field("word_data", want.idx, 64'(word_data), 64'(want.data));
        check_field("last", want.idx, 64'(last), 64'(want.last));
        check_field("dst_mac", want.idx, 64'(dst_mac), 64'(want.dmac));
        check_field("frame_length", want.idx, 64'(frame_length), 64'(want.flen));
        check_field("arp_request", want.idx, 64'(arp_request), 64'(want.req));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int          mode, ph, k;
    logic [31:0] pace;
    pacing_cfg   = PACING_RESET;
    board_ip_cfg = BOARD_IP_RESET;
    udp_dflt_cfg = UDP_LEN_RESET;
    ip_dflt_cfg  = IP_LEN_RESET;
    tx_base_cfg  = '0;
    restart_pacer();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_idling(0, 0);

    // every tick but the clear fires, widest lengths and address, arp request sequence, echo extremes
    program_regs(32'd1, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    tick_q.push_back(mk_tick(0, 0, 16'h0, 16'h0, 0, 48'h123456789ABC));
    tick_q.push_back(mk_tick(0, 0, 16'h0, 16'h0, 0, 48'h0));
    tick_q.push_back(mk_tick(0, 0, 16'h0, 16'h0, 1, BCAST_MAC));
    tick_q.push_back(mk_tick(0, 0, 16'h0, 16'h0, 1, 48'h0));
    tick_q.push_back(mk_tick(0, 0, 16'h0, 16'h0, 0, 48'hA5A5A5A5A5A5));
    tick_q.push_back(mk_tick(0, 1, 16'h0, 16'h0, 1, 48'h5A5A5A5A5A5A));
    tick_q.push_back(mk_tick(0, 1, 16'hFFFF, 16'hFFFF, 0, 48'h0));
    tick_q.push_back(mk_tick(1, 1, 16'hFFFF, 16'hFFFF, 1, BCAST_MAC));
    tick_q.push_back(mk_tick(0, 0, 16'h0, 16'h0, 1, 48'h0000FFFF0000));
    settle();

    // smallest lengths, later echo notice overwrites, clear drops a pending echo
    program_regs(32'd3, 32'h0, 16'd8, 16'd28, 16'h0);
    tick_q.push_back(mk_tick(1, 0, 16'h0, 16'h0, 0, 48'h0));
    tick_q.push_back(mk_tick(0, 1, 16'd100, 16'd120, 1, 48'h1));
    tick_q.push_back(mk_tick(0, 1, 16'd200, 16'd220, 1, 48'h2));
    tick_q.push_back(mk_tick(0, 0, 16'h0, 16'h0, 1, 48'h3));
    tick_q.push_back(mk_tick(0, 1, 16'd300, 16'd320, 0, 48'h0));
    tick_q.push_back(mk_tick(1, 0, 16'h0, 16'h0, 0, 48'h0));
    tick_q.push_back(mk_tick(0, 0, 16'h0, 16'h0, 0, 48'h0));
    tick_q.push_back(mk_tick(0, 0, 16'h0, 16'h0, 0, 48'h0));
    tick_q.push_back(mk_tick(0, 0, 16'h0, 16'h0, 1, 48'h800000000001));
    settle();

    // pacing of zero fires on every tick
    program_regs(32'd0, 32'h5555AAAA, 16'd40, 16'd60, 16'h8000);
    tick_q.push_back(mk_tick(0, 0, 16'h0, 16'h0, 1, 48'hFEDCBA987654));
    tick_q.push_back(mk_tick(0, 1, 16'd9, 16'd29, 0, 48'h0));
    tick_q.push_back(mk_tick(0, 0, 16'h0, 16'h0, 0, 48'h0));
    settle();

    // widest pacing: nothing fires
    program_regs(32'hFFFFFFFF, 32'hAAAA5555, 16'd100, 16'd120, 16'h7FFF);
    tick_q.push_back(mk_tick(0, 1, 16'd50, 16'd70, 1, 48'h1));
    tick_q.push_back(mk_tick(1, 0, 16'h0, 16'h0, 0, 48'h0));
    tick_q.push_back(mk_tick(0, 0, 16'h0, 16'h0, 0, 48'h0));
    settle();

    for (mode = 0; mode < 3; mode++) begin
      for (ph = 0; ph < 3; ph++) begin
        case (mode)
          0:       set_idling(6, 58);
          1:       set_idling(58, 6);
          default: set_idling(0, 0);
        endcase
        case ($urandom_range(9))
          0:       pace = 32'd0;
          7, 8:    pace = $urandom_range(12, 4);
          9:       pace = 32'd1;
          default: pace = $urandom_range(3, 1);
        endcase
        if (mode == 2 && ph == 0) pace = 32'd1;
        program_regs(pace, $urandom,
                     $urandom_range(1) ? 16'($urandom_range(60, 8))
                                       : 16'($urandom_range(65535, 8)),
                     16'($urandom_range(65535, 28)), 16'($urandom_range(65535)));
        for (k = 0; k < RAND_PER_PHASE; k++) tick_q.push_back(random_tick());
        // receiver holds off while ticks keep coming, so the burst queue fills
        if (mode == 2 && ph == 0) begin
          hold_go <= 1'b1;
          @(posedge clk);
          hold_go <= 1'b0;
        end
        settle();
      end
    end

    if (datagram_q.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", datagram_q.size()));
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
